// ===== design/sli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int TUSER_BITS = 2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PROBE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

`default_nettype wire

// ===== design/sorted_list_intersection.sv =====
// Load request: it goes to the done state, then its result is registered onto the master side.
// Probe request: list A entries from the pointer on are compared in turn, smaller ones skipped,
// until a match, a larger entry or the end of list A; a used-up list A goes straight to done.
// One request is in work at a time; the next is taken when the result leaves the work stage,
// so output stalls also hold off the next request.
// Reset is synchronous, active low: count, pointer, overflow flag and output valid clear.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_intersection (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: item_value.
    input  wire logic [sli_pkg::TDATA_BITS-1:0]  s_axis_tdata,
    // tuser: action, starts_list.
    input  wire logic [sli_pkg::TUSER_BITS-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: match_value.
    output logic      [sli_pkg::TDATA_BITS-1:0]  m_axis_tdata,
    // tuser: matched, overflowed.
    output logic      [sli_pkg::TUSER_BITS-1:0]  m_axis_tuser
);

    sli_pkg::t_state r_state, n_state;
    logic [sli_pkg::CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [sli_pkg::CNT_BITS-1:0]   r_ptr, n_ptr;
    logic                           r_ovf, n_ovf;
    logic [sli_pkg::VALUE_BITS-1:0] r_val, n_val;
    logic                           r_res_match, n_res_match;
    logic [sli_pkg::VALUE_BITS-1:0] r_res_value, n_res_value;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_match, n_out_match;
    logic [sli_pkg::VALUE_BITS-1:0] r_out_value, n_out_value;
    logic                           r_out_ovf, n_out_ovf;

    logic                           w_we;
    logic [sli_pkg::ADDR_BITS-1:0]  w_waddr;
    logic [sli_pkg::ADDR_BITS-1:0]  w_raddr;
    logic [sli_pkg::VALUE_BITS-1:0] w_rdata;
    logic [sli_pkg::CNT_BITS-1:0]   w_base;
    logic [sli_pkg::CNT_BITS-1:0]   w_ptr_inc;

    sli_ram #(
        .WIDTH(sli_pkg::VALUE_BITS),
        .DEPTH(sli_pkg::DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(s_axis_tdata[sli_pkg::VALUE_BITS-1:0]),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign s_axis_tready = (r_state == sli_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = sli_pkg::TDATA_BITS'(r_out_value);
    assign m_axis_tuser  = {r_out_ovf, r_out_match};

    assign w_base    = s_axis_tuser[1] ? '0 : r_cnt;
    assign w_ptr_inc = r_ptr + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_ovf       = r_ovf;
        n_val       = r_val;
        n_res_match = r_res_match;
        n_res_value = r_res_value;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_match = r_out_match;
        n_out_value = r_out_value;
        n_out_ovf   = r_out_ovf;
        w_we        = 1'b0;
        w_waddr     = w_base[sli_pkg::ADDR_BITS-1:0];
        w_raddr     = r_ptr[sli_pkg::ADDR_BITS-1:0];
        case (r_state)
            sli_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res_match = 1'b0;
                    n_res_value = '0;
                    if (s_axis_tuser[0] == sli_pkg::ACT_LOAD) begin
                        if (s_axis_tuser[1]) begin
                            n_ptr = '0;
                            n_ovf = 1'b0;
                        end
                        if (w_base < sli_pkg::CNT_BITS'(sli_pkg::DEPTH)) begin
                            w_we  = 1'b1;
                            n_cnt = w_base + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_state = sli_pkg::ST_DONE;
                    end else begin
                        n_val = s_axis_tdata[sli_pkg::VALUE_BITS-1:0];
                        if (r_ptr < r_cnt) begin
                            n_state = sli_pkg::ST_CMP;
                        end else begin
                            n_state = sli_pkg::ST_DONE;
                        end
                    end
                end
            end
            sli_pkg::ST_CMP: begin
                w_raddr = w_ptr_inc[sli_pkg::ADDR_BITS-1:0];
                if (w_rdata == r_val) begin
                    n_res_match = 1'b1;
                    n_res_value = r_val;
                    n_ptr       = w_ptr_inc;
                    n_state     = sli_pkg::ST_DONE;
                end else if ($signed(w_rdata) < $signed(r_val)) begin
                    n_ptr = w_ptr_inc;
                    if (w_ptr_inc >= r_cnt) begin
                        n_state = sli_pkg::ST_DONE;
                    end
                end else begin
                    n_state = sli_pkg::ST_DONE;
                end
            end
            sli_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_match = r_res_match;
                    n_out_value = r_res_value;
                    n_out_ovf   = r_ovf;
                    n_state     = sli_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sli_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sli_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ptr       <= n_ptr;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val       <= n_val;
        r_res_match <= n_res_match;
        r_res_value <= n_res_value;
        r_out_match <= n_out_match;
        r_out_value <= n_out_value;
        r_out_ovf   <= n_out_ovf;
    end

endmodule

`default_nettype wire

// ===== design/sli_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/sli_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sli_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [sli_pkg::TDATA_BITS-1:0]  s_axis_tdata,
    input wire logic [sli_pkg::TUSER_BITS-1:0]  s_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [sli_pkg::TDATA_BITS-1:0]  m_axis_tdata,
    input wire logic [sli_pkg::TUSER_BITS-1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("Result changed while stalled.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("Unmatched result carries a nonzero value.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Request accepted while another is in work.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result valid right after reset.");

endmodule

bind sorted_list_intersection sli_checker u_sli_checker (.*);

`default_nettype wire
